>>> design/tbs_pkg.sv
// Shared types and constants of the token bucket shaper.
`timescale 1ns / 1ps
package tbs_pkg;

  // Kind of an input beat.
  typedef enum logic [0:0] {
    OP_TICK    = 1'b0,
    OP_ARRIVAL = 1'b1
  } op_t;

  localparam int TOKEN_W = 8;
  localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 8'd5;

  // Result queue in the back end, between the front end and the output channel.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_LW    = $clog2(CMDQ_DEPTH + 1);

endpackage

>>> design/tbs_if.sv
// Valid/ready channel interfaces for input beats and result beats.
`timescale 1ns / 1ps
interface tbs_in_if #(
  parameter int PACKET_WIDTH = 32
);
  logic              valid;
  logic              ready;
  tbs_pkg::op_t      operation;
  logic [PACKET_WIDTH-1:0] packet_data;

  modport source (output valid, output operation, output packet_data, input ready);
  modport sink   (input valid, input operation, input packet_data, output ready);
endinterface

interface tbs_out_if #(
  parameter int PACKET_WIDTH = 32,
  parameter int LEVEL_W      = 7
);
  logic                    valid;
  logic                    ready;
  logic                    released;
  logic [PACKET_WIDTH-1:0] released_packet;
  logic                    dropped;
  logic [7:0]              tokens_left;
  logic [LEVEL_W-1:0]      queue_level;

  modport source (output valid, output released, output released_packet, output dropped,
                  output tokens_left, output queue_level, input ready);
  modport sink   (input valid, input released, input released_packet, input dropped,
                  input tokens_left, input queue_level, output ready);
endinterface

>>> design/tbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/tbs_front.sv
// Front end: accepts beats, updates token and queue counters, owns the packet store.
`timescale 1ns / 1ps
module tbs_front #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PACKET_WIDTH = 32,
  parameter int LEVEL_W      = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tbs_pkg::TOKEN_W-1:0] cfg_wr_data,
  tbs_in_if.sink                      item,
  input  logic                        space,
  output logic                        push,
  output logic                        res_released,
  output logic [PACKET_WIDTH-1:0]     res_packet,
  output logic                        res_dropped,
  output logic [tbs_pkg::TOKEN_W-1:0] res_tokens,
  output logic [LEVEL_W-1:0]          res_level
);
  import tbs_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [TOKEN_W-1:0] capacity;
  logic [TOKEN_W-1:0] tokens, tokens_next;
  logic [LEVEL_W-1:0] waiting, waiting_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;

  logic               accept;
  logic               store_wr;
  logic               drop;
  logic               rel;
  logic               bypass;
  logic [TOKEN_W-1:0] tok_a;
  logic [LEVEL_W-1:0] wait_a;
  logic [PACKET_WIDTH-1:0] ram_rdata;

  // Second stage: decision of the previous beat, waiting for the store read.
  logic                    s2_valid;
  logic                    s2_released;
  logic                    s2_bypass;
  logic [PACKET_WIDTH-1:0] s2_bypass_data;
  logic                    s2_dropped;
  logic [TOKEN_W-1:0]      s2_tokens;
  logic [LEVEL_W-1:0]      s2_level;

  assign item.ready = space;
  assign accept     = item.valid & item.ready;

  always_comb begin
    tok_a       = tokens;
    wait_a      = waiting;
    tail_next   = tail;
    head_next   = head;
    store_wr    = 1'b0;
    drop        = 1'b0;
    if (item.operation == OP_TICK) begin
      if (tokens < capacity) begin
        tok_a = tokens + TOKEN_W'(1);
      end
    end else begin
      if (waiting == LEVEL_W'(QUEUE_DEPTH)) begin
        drop = 1'b1;
      end else begin
        store_wr = 1'b1;
        wait_a   = waiting + LEVEL_W'(1);
        tail_next = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + AW'(1);
      end
    end
    rel          = (wait_a != '0) && (tok_a != '0);
    // An arrival into an empty queue, if released, takes its packet from the beat itself.
    bypass       = store_wr && (waiting == '0);
    tokens_next  = tok_a;
    waiting_next = wait_a;
    if (rel) begin
      tokens_next  = tok_a - TOKEN_W'(1);
      waiting_next = wait_a - LEVEL_W'(1);
      head_next    = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      tokens   <= '0;
      waiting  <= '0;
      head     <= '0;
      tail     <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      s2_valid <= accept;
      if (accept) begin
        tokens  <= tokens_next;
        waiting <= waiting_next;
        head    <= head_next;
        tail    <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_released    <= rel;
    s2_bypass      <= bypass;
    s2_bypass_data <= item.packet_data;
    s2_dropped     <= drop;
    s2_tokens      <= tokens_next;
    s2_level       <= waiting_next;
  end

  tbs_ram #(
    .WIDTH (PACKET_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept & store_wr),
    .wr_addr (tail),
    .wr_data (item.packet_data),
    .rd_addr (head),
    .rd_data (ram_rdata)
  );

  assign push         = s2_valid;
  assign res_released = s2_released;
  assign res_packet   = !s2_released ? '0 : (s2_bypass ? s2_bypass_data : ram_rdata);
  assign res_dropped  = s2_dropped;
  assign res_tokens   = s2_tokens;
  assign res_level    = s2_level;

endmodule

>>> design/tbs_back.sv
// Back end: short result queue that drives the output channel.
`timescale 1ns / 1ps
module tbs_back #(
  parameter int PACKET_WIDTH = 32,
  parameter int LEVEL_W      = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        res_released,
  input  logic [PACKET_WIDTH-1:0]     res_packet,
  input  logic                        res_dropped,
  input  logic [tbs_pkg::TOKEN_W-1:0] res_tokens,
  input  logic [LEVEL_W-1:0]          res_level,
  output logic                        space,
  tbs_out_if.source                   result
);
  import tbs_pkg::*;

  localparam int RES_W = 1 + PACKET_WIDTH + 1 + TOKEN_W + LEVEL_W;

  logic [RES_W-1:0]   slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_LW-1:0] count;
  logic               pop;

  assign pop = result.valid & result.ready;

  // Room is checked against the beat already in the front end's second stage.
  assign space = (count + CMDQ_LW'(push)) < CMDQ_LW'(CMDQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMDQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMDQ_AW'(1);
      end
      count <= count + CMDQ_LW'(push) - CMDQ_LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= {res_released, res_packet, res_dropped, res_tokens, res_level};
    end
  end

  assign result.valid = (count != '0);
  assign {result.released, result.released_packet, result.dropped,
          result.tokens_left, result.queue_level} = slots[rd_ptr];

endmodule

>>> design/token_bucket_shaper.sv
// Top level of the token bucket traffic shaper.
`timescale 1ns / 1ps
// Token bucket shaper. Every input beat is either a token tick or a packet
// descriptor arrival, and every input beat yields exactly one result beat. A
// tick adds a token unless the bucket already holds capacity tokens;
// an arrival is appended to a packet queue of QUEUE_DEPTH entries, or dropped
// and flagged when the queue is full. After each beat, if a packet waits and a
// token is held, the head packet is released and one token is spent. The
// block takes one input beat per clock cycle while the result queue has
// room. The front end settles the token count, queue level and queue
// pointers for a beat combinationally and registers them at the accepting
// edge. A result passes through the front end's second stage and a slot
// of the result queue before the output channel offers it. The second
// stage covers the registered read of the packet store; the result queue
// offers a beat right after the edge that writes it. A four-beat result
// queue lets the input side keep running while the output stalls briefly.
// The packet store needs no clearing pass after reset, since only entries
// written by an arrival are ever read. The capacity register resets to five
// and should only be written while no beats are in flight.
module token_bucket_shaper #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PACKET_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tbs_pkg::TOKEN_W-1:0] cfg_wr_data,
  tbs_in_if.sink                      item,
  tbs_out_if.source                   result
);
  import tbs_pkg::*;

  // The queue level must be able to show a completely full queue.
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  logic                    push;
  logic                    space;
  logic                    res_released;
  logic [PACKET_WIDTH-1:0] res_packet;
  logic                    res_dropped;
  logic [TOKEN_W-1:0]      res_tokens;
  logic [LEVEL_W-1:0]      res_level;

  // The front end owns the token, queue and capacity state and decides each beat's fate.
  tbs_front #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PACKET_WIDTH (PACKET_WIDTH),
    .LEVEL_W      (LEVEL_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item         (item),
    .space        (space),
    .push         (push),
    .res_released (res_released),
    .res_packet   (res_packet),
    .res_dropped  (res_dropped),
    .res_tokens   (res_tokens),
    .res_level    (res_level)
  );

  // The back end buffers finished results until the consumer takes them.
  tbs_back #(
    .PACKET_WIDTH (PACKET_WIDTH),
    .LEVEL_W      (LEVEL_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res_released (res_released),
    .res_packet   (res_packet),
    .res_dropped  (res_dropped),
    .res_tokens   (res_tokens),
    .res_level    (res_level),
    .space        (space),
    .result       (result)
  );

endmodule

>>> tb/sv/tbs_checker.sv
// Checker for the token bucket shaper: predicts each result beat and compares it.
`timescale 1ns / 1ps
module tbs_checker
  import tbs_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PACKET_WIDTH = 32,
  parameter int LEVEL_W      = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [TOKEN_W-1:0] cfg_wr_data,
  tbs_in_if                  item,
  tbs_out_if                 result,
  output int                 errors,
  output int                 outstanding,
  output int                 checked,
  output int                 releases,
  output int                 drops
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                    released;
    logic [PACKET_WIDTH-1:0] released_packet;
    logic                    dropped;
    logic [TOKEN_W-1:0]      tokens_left;
    logic [LEVEL_W-1:0]      queue_level;
  } shaper_result_t;

  // Private copy of the shaper state.
  logic [TOKEN_W-1:0]      capacity;
  logic [TOKEN_W-1:0]      tokens;
  logic [PACKET_WIDTH-1:0] pkt_store [QUEUE_DEPTH];
  int                      head;
  int                      tail;
  logic [LEVEL_W-1:0]      level;

  shaper_result_t          due_results [$];

  // Applies one input beat to the state and returns the result it must produce.
  function automatic shaper_result_t advance_bucket(op_t op, logic [PACKET_WIDTH-1:0] data);
    shaper_result_t res;
    res = '0;
    if (op == OP_TICK) begin
      if (tokens < capacity) tokens = tokens + 1'b1;
    end else if (int'(level) >= QUEUE_DEPTH) begin
      res.dropped = 1'b1;
    end else begin
      pkt_store[tail] = data;
      tail = (tail + 1) % QUEUE_DEPTH;
      level = level + 1'b1;
    end
    if (level != '0 && tokens != '0) begin
      res.released        = 1'b1;
      res.released_packet = pkt_store[head];
      head   = (head + 1) % QUEUE_DEPTH;
      level  = level - 1'b1;
      tokens = tokens - 1'b1;
    end
    res.tokens_left = tokens;
    res.queue_level = level;
    return res;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    shaper_result_t want;
    shaper_result_t got;
    if (rst) begin
      capacity = CAPACITY_RESET;
      tokens   = '0;
      head     = 0;
      tail     = 0;
      level    = '0;
      due_results.delete();
      errors   = 0;
      checked  = 0;
      releases = 0;
      drops    = 0;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (item.valid && item.ready) begin
        want = advance_bucket(item.operation, item.packet_data);
        releases += want.released;
        drops    += want.dropped;
        due_results.push_back(want);
      end
      if (result.valid && result.ready) begin
        got.released        = result.released;
        got.released_packet = result.released_packet;
        got.dropped         = result.dropped;
        got.tokens_left     = result.tokens_left;
        got.queue_level     = result.queue_level;
        if (due_results.size() == 0) begin
          note_error($sformatf("Result beat with nothing due: rel=%0b pkt=%h drop=%0b tok=%0d lvl=%0d",
                               got.released, got.released_packet, got.dropped,
                               got.tokens_left, got.queue_level));
        end else begin
          want = due_results.pop_front();
          checked++;
          if (got.released !== want.released || got.released_packet !== want.released_packet ||
              got.dropped !== want.dropped || got.tokens_left !== want.tokens_left ||
              got.queue_level !== want.queue_level) begin
            note_error($sformatf({"Result %0d mismatch: expected rel=%0b pkt=%h drop=%0b ",
                                  "tok=%0d lvl=%0d, got rel=%0b pkt=%h drop=%0b tok=%0d lvl=%0d"},
                                 checked, want.released, want.released_packet, want.dropped,
                                 want.tokens_left, want.queue_level, got.released,
                                 got.released_packet, got.dropped, got.tokens_left,
                                 got.queue_level));
          end
        end
      end
    end
    outstanding <= due_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the token bucket shaper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import tbs_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int PACKET_WIDTH = 32;
  localparam int LEVEL_W      = 7;
  // Roughly 1400 beats, with the limit set many times over the slowest case.
  localparam int CYCLE_LIMIT  = 300000;
  // Cycles waited at the end after the last result has been seen.
  localparam int TAIL_CYCLES  = 8;
  localparam int IDLE_PCT     = 15;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [TOKEN_W-1:0] cfg_wr_data;
  // While calm is high neither side idles, so the block runs at full rate.
  logic               calm = 1'b0;

  int beats_sent;
  int cap_writes;
  int cycle_count;
  int errors;
  int outstanding;
  int checked;
  int releases;
  int drops;

  tbs_in_if  #(.PACKET_WIDTH(PACKET_WIDTH)) item_ch ();
  tbs_out_if #(.PACKET_WIDTH(PACKET_WIDTH), .LEVEL_W(LEVEL_W)) result_ch ();

  token_bucket_shaper #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_WIDTH(PACKET_WIDTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item       (item_ch),
    .result     (result_ch)
  );

  tbs_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_WIDTH(PACKET_WIDTH),
    .LEVEL_W     (LEVEL_W)
  ) scoreboard (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item       (item_ch),
    .result     (result_ch),
    .errors     (errors),
    .outstanding(outstanding),
    .checked    (checked),
    .releases   (releases),
    .drops      (drops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls in about one cycle of seven, except while calm is
  // set. Ready is updated at every edge, so stalls land on every phase of the
  // block's two-stage result path and its four-beat result queue.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offers one input beat and returns at the edge that accepts it. Random
  // idle cycles go in front of the beat. Valid is set only once per beat, so a
  // back-to-back beat never sees valid lowered and raised in the same step.
  task automatic send_beat(op_t op, logic [PACKET_WIDTH-1:0] data);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.operation   <= op;
    item_ch.packet_data <= data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Stops offering beats and waits until every predicted result has been
  // seen. The first edge lets the checker count a beat accepted just now.
  task automatic wait_for_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // The capacity register may only change while no beats are in flight.
  task automatic write_capacity(logic [TOKEN_W-1:0] value);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_writes++;
  endtask

  // Random ticks and arrivals; arrival_pct steers the bucket toward empty
  // (arrival heavy, queue fills and drops) or toward full (tick heavy).
  task automatic random_traffic(int count, int arrival_pct);
    op_t op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < arrival_pct) ? OP_ARRIVAL : OP_TICK;
      send_beat(op, $urandom());
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped by the cycle limit at %0d cycles.", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= CAPACITY_RESET;
    item_ch.valid       <= 1'b0;
    item_ch.operation   <= OP_TICK;
    item_ch.packet_data <= '0;
    beats_sent = 0;
    cap_writes = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, capacity at its reset value of five. Arrivals into an
    // empty bucket wait in the queue and report no release, with a zero
    // descriptor on the result.
    send_beat(OP_ARRIVAL, 32'h0000_0000);
    send_beat(OP_ARRIVAL, 32'hFFFF_FFFF);
    // Each tick now releases one waiting packet; the tick's own data is junk
    // that must be ignored.
    send_beat(OP_TICK, 32'hDEAD_BEEF);
    send_beat(OP_TICK, 32'hFFFF_FFFF);
    // Six ticks into an empty queue fill the bucket; the last one is discarded.
    repeat (6) send_beat(OP_TICK, 32'h1234_5678);
    // With tokens held, an arrival passes straight through.
    send_beat(OP_ARRIVAL, 32'hA5A5_A5A5);

    // Capacity lowered below the four tokens held: they stay, ticks add none.
    write_capacity(8'd2);
    repeat (2) send_beat(OP_TICK, 32'h0);
    send_beat(OP_ARRIVAL, 32'h5A5A_5A5A);

    // Capacity zero: held tokens are spent by arrivals, then nothing moves.
    write_capacity(8'd0);
    repeat (3) send_beat(OP_ARRIVAL, $urandom());
    send_beat(OP_ARRIVAL, 32'h8000_0001);
    send_beat(OP_TICK, 32'h0);

    // Widest capacity: the waiting packet leaves on the next tick.
    write_capacity(8'd255);
    send_beat(OP_TICK, 32'h0);

    // Full queue: with no tokens coming, 64 arrivals fill the queue and the
    // rest are dropped. Then ticks drain it completely.
    write_capacity(8'd0);
    repeat (QUEUE_DEPTH + 4) send_beat(OP_ARRIVAL, $urandom());
    write_capacity(8'd255);
    repeat (QUEUE_DEPTH + 2) send_beat(OP_TICK, $urandom());

    // Random part over several capacity settings.
    write_capacity(8'd1);
    random_traffic(250, 50);

    // Tick heavy with the widest bucket piles up tokens, then the capacity is
    // lowered beneath them and the traffic turns arrival heavy.
    write_capacity(8'd255);
    random_traffic(150, 20);
    write_capacity(8'd3);
    random_traffic(150, 60);

    // A long stretch with no idling on either side.
    write_capacity(TOKEN_W'($urandom_range(254, 1)));
    calm <= 1'b1;
    random_traffic(300, 50);
    calm <= 1'b0;

    // Zero capacity with arrival heavy traffic runs into drops.
    write_capacity(8'd0);
    random_traffic(80, 70);

    write_capacity(TOKEN_W'($urandom_range(255, 0)));
    random_traffic(250, 55);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result beats of %0d input beats: %0d releases, %0d drops.",
             checked, beats_sent, releases, drops);
    $display("Capacity written %0d times (zero, one, 255, lowered below held tokens); %0d errors.",
             cap_writes, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tbs_pkg.sv
design/tbs_if.sv
design/tbs_ram.sv
design/tbs_front.sv
design/tbs_back.sv
design/token_bucket_shaper.sv
tb/sv/tbs_checker.sv
tb/sv/tb_top.sv
